@@ design/bsd_pkg.sv @@
// ----------------------------------------------------------------------------
// Blank scanline doubler package
// Beat types, register indexes, codes and reset values shared by the block.
// ----------------------------------------------------------------------------
package bsd_pkg;

  // Opcode carried by an input beat.
  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_e;

  // Line mode register values.
  typedef enum logic {
    MODE_PLAIN    = 1'b0,
    MODE_ADAPTIVE = 1'b1
  } line_mode_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_LINE_MODE    = 3'd0,
    CFG_ROW_WIDTH    = 3'd1,
    CFG_FRAME_HEIGHT = 3'd2,
    CFG_BLANK_CUTOFF = 3'd3,
    CFG_MIN_RUN      = 3'd4
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic        LineModeReset  = 1'b1;
  localparam logic [10:0] RowWidthReset  = 11'd640;
  localparam logic [15:0] HeightReset    = 16'd400;
  localparam logic [10:0] CutoffReset    = 11'd0;
  localparam logic [10:0] MinRunReset    = 11'd30;

  // Depth of the result queue in front of the output port.
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = 2;
  localparam int unsigned FifoCntW  = 3;

  typedef struct packed {
    logic        operation;
    logic [31:0] pixel_bgra;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] pixel_out;
    logic        end_of_row;
    logic        end_of_frame;
  } out_beat_t;

  // Control carried alongside a result through the read pipeline.
  typedef struct packed {
    logic       valid;
    logic       eor;
    logic       eof;
    logic       keep;   // first or last row of the frame: pass through
    logic       rrow;   // row is marked for replacement
    logic       rall;   // replace the whole row
    logic [1:0] oslot;  // store slot of the row being output
  } pipe_ctrl_t;

endpackage

@@ design/blank_scanline_doubler_core.sv @@
// ----------------------------------------------------------------------------
// Blank scanline doubler core
// Fills blank scanlines, or long zero runs, from the row above.
// Results pass the p1 and p2 registers and the result queue before output.
// Throughput: one beat per cycle; the row store takes one write and two reads
// per cycle and the run tables one lookup per cycle, which sets this rate.
// Input stalls only when the four-entry result queue could overflow.
// Reset clears all control state and loads register defaults; stores need none.
// ----------------------------------------------------------------------------
module blank_scanline_doubler_core #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  bsd_pkg::in_beat_t               in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output bsd_pkg::out_beat_t              out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bsd_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [bsd_pkg::CfgDataW-1:0]    cfg_data_i
);

  localparam int unsigned ColW  = $clog2(MAX_WIDTH);
  localparam int unsigned LenW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned TailW = $clog2(2 * MAX_WIDTH + 1);

  // Slot arithmetic modulo three for the three row slots.
  function automatic logic [1:0] slot_next(input logic [1:0] s);
    return (s == 2'd2) ? 2'd0 : s + 2'd1;
  endfunction

  function automatic logic [1:0] slot_prev(input logic [1:0] s);
    return (s == 2'd0) ? 2'd2 : s - 2'd1;
  endfunction

  // Configuration registers. The port never pushes back.
  logic        line_mode_q;
  logic [10:0] row_width_q;
  logic [15:0] frame_height_q;
  logic [10:0] cutoff_q;
  logic [10:0] min_run_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_mode_q    <= bsd_pkg::LineModeReset;
      row_width_q    <= bsd_pkg::RowWidthReset;
      frame_height_q <= bsd_pkg::HeightReset;
      cutoff_q       <= bsd_pkg::CutoffReset;
      min_run_q      <= bsd_pkg::MinRunReset;
    end else if (cfg_valid_i) begin
      unique case (bsd_pkg::cfg_idx_e'(cfg_index_i))
        bsd_pkg::CFG_LINE_MODE:    line_mode_q    <= cfg_data_i[0];
        bsd_pkg::CFG_ROW_WIDTH:    row_width_q    <= cfg_data_i[10:0];
        bsd_pkg::CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        bsd_pkg::CFG_BLANK_CUTOFF: cutoff_q       <= cfg_data_i[10:0];
        bsd_pkg::CFG_MIN_RUN:      min_run_q      <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  // Effective geometry: a zero width or height acts as one, and the width is
  // clamped to the size of a row slot.
  logic [LenW-1:0] eff_w;
  logic [15:0]     eff_h;

  always_comb begin
    if (row_width_q == '0) begin
      eff_w = LenW'(1);
    end else if (32'(row_width_q) > 32'(MAX_WIDTH)) begin
      eff_w = LenW'(MAX_WIDTH);
    end else begin
      eff_w = LenW'(row_width_q);
    end
    eff_h = (frame_height_q == '0) ? 16'd1 : frame_height_q;
  end

  // Frame position and run tracking state.
  logic [ColW-1:0]  col_q;
  logic [15:0]      row_q;
  logic [1:0]       wslot_q;       // row_q modulo three
  logic [TailW-1:0] tail_q;        // tail beats still owed after the frame
  logic [LenW-1:0]  open_len_q;
  logic [ColW-1:0]  open_start_q;
  logic [1:0]       flags_q;       // [1] previous row has data, [0] this row
  logic [LenW-1:0]  sum0_q, sum1_q;
  logic             rrow_q, rall_q;

  bsd_pkg::pipe_ctrl_t p1_q, p2_q;
  bsd_pkg::pipe_ctrl_t p1_d;
  logic [31:0]         cur2_q, above2_q;
  logic [31:0]         cur_rd, above_rd;
  logic [LenW-1:0]     len_rd;
  logic [bsd_pkg::FifoCntW-1:0] fifo_level;

  logic accept, in_tail, is_drain, tail_go, pix_go;
  logic last_col, tail_eof, tail_eor;

  // Two beats may still be in the read pipeline, so hold off while the queue
  // could not take them together with a new one.
  assign in_stall_o = (32'(fifo_level) + 32'(p1_q.valid) + 32'(p2_q.valid))
                      >= 32'(bsd_pkg::FifoDepth);

  assign accept   = in_valid_i && !in_stall_o;
  assign in_tail  = (tail_q != '0);
  assign is_drain = (in_data_i.operation == bsd_pkg::OP_DRAIN);
  assign tail_go  = accept && in_tail && is_drain;
  assign pix_go   = accept && !in_tail && !is_drain;
  assign last_col = (LenW'(col_q) + LenW'(1)) >= eff_w;
  assign tail_eof = (tail_q == TailW'(1));
  assign tail_eor = tail_eof || last_col;

  // Run bookkeeping for the incoming pixel. A run is closed when a nonzero
  // pixel ends it or when the row ends; it qualifies when long enough.
  logic            start_row, px_zero, run_close, run_qual;
  logic [LenW-1:0] open_len0, run_len1, close_len, sum_cur0, sum_add;
  logic [ColW-1:0] run_start1, close_start;
  logic [1:0]      flags0;
  logic            this_data, prev_data;

  always_comb begin
    start_row = (col_q == '0);
    px_zero   = (in_data_i.pixel_bgra == 32'd0);
    open_len0 = start_row ? '0 : open_len_q;
    flags0    = start_row ? {flags_q[1], 1'b0} : flags_q;
    sum_cur0  = start_row ? '0 : (row_q[0] ? sum1_q : sum0_q);
    if (px_zero) begin
      run_start1  = (open_len0 == '0) ? col_q : open_start_q;
      run_len1    = open_len0 + LenW'(1);
      run_close   = last_col;
      close_len   = run_len1;
      close_start = run_start1;
    end else begin
      run_start1  = open_start_q;
      run_len1    = '0;
      run_close   = (open_len0 != '0);
      close_len   = open_len0;
      close_start = open_start_q;
    end
    run_qual  = run_close && (32'(close_len) >= 32'(min_run_q));
    sum_add   = run_qual ? close_len : '0;
    this_data = flags0[0] || !px_zero;
    prev_data = flags0[1];
  end

  // Frame end: the last two rows (one for a single-row frame) go out as tail.
  logic        frame_last, two_rows;
  logic [16:0] row_inc;

  assign row_inc    = {1'b0, row_q} + 17'd1;
  assign frame_last = row_inc >= {1'b0, eff_h};
  assign two_rows   = (eff_h >= 16'd2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q        <= '0;
      row_q        <= '0;
      wslot_q      <= '0;
      tail_q       <= '0;
      open_len_q   <= '0;
      open_start_q <= '0;
      flags_q      <= '0;
      sum0_q       <= '0;
      sum1_q       <= '0;
      rrow_q       <= 1'b0;
      rall_q       <= 1'b0;
    end else if (tail_go) begin
      tail_q <= tail_q - TailW'(1);
      if (tail_eof) begin
        row_q      <= '0;
        col_q      <= '0;
        wslot_q    <= '0;
        flags_q    <= '0;
        open_len_q <= '0;
        rrow_q     <= 1'b0;
      end else if (tail_eor) begin
        col_q   <= '0;
        row_q   <= row_q + 16'd1;
        wslot_q <= slot_next(wslot_q);
      end else begin
        col_q <= col_q + ColW'(1);
      end
    end else if (pix_go) begin
      if (row_q[0]) begin
        sum1_q <= sum_cur0 + sum_add;
      end else begin
        sum0_q <= sum_cur0 + sum_add;
      end
      open_start_q <= run_start1;
      open_len_q   <= (px_zero && !last_col) ? run_len1 : '0;
      if (last_col) begin
        flags_q <= {this_data, 1'b0};
        col_q   <= '0;
        // The decision for the row above is taken now that this row is done.
        if (row_q != '0) begin
          if (line_mode_q == bsd_pkg::MODE_PLAIN) begin
            rrow_q <= !prev_data && this_data;
            rall_q <= 1'b1;
          end else begin
            rrow_q <= this_data &&
                      (32'(row_q[0] ? sum0_q : sum1_q) > 32'(cutoff_q));
            rall_q <= 1'b0;
          end
        end else begin
          rrow_q <= 1'b0;
        end
        if (frame_last) begin
          if (two_rows) begin
            tail_q  <= TailW'(eff_w) << 1;
            row_q   <= eff_h - 16'd2;
            wslot_q <= slot_prev(wslot_q);
          end else begin
            tail_q  <= TailW'(eff_w);
            row_q   <= '0;
            wslot_q <= '0;
          end
        end else begin
          row_q   <= row_q + 16'd1;
          wslot_q <= slot_next(wslot_q);
        end
      end else begin
        flags_q <= {flags0[1], this_data};
        col_q   <= col_q + ColW'(1);
      end
    end
  end

  // Read side. In a pixel beat the output row lies two rows behind, in a
  // tail beat it is the current row. The row above shares its slot with the
  // row now being written, so the read returns it before it is overwritten.
  logic [1:0] oslot, aslot;

  assign oslot = in_tail ? wslot_q : slot_next(wslot_q);
  assign aslot = in_tail ? slot_prev(wslot_q) : wslot_q;

  always_comb begin
    p1_d       = '0;
    p1_d.rrow  = rrow_q;
    p1_d.rall  = rall_q;
    p1_d.oslot = oslot;
    if (tail_go) begin
      p1_d.valid = 1'b1;
      p1_d.eor   = tail_eor;
      p1_d.eof   = tail_eof;
      p1_d.keep  = (row_q == '0) || frame_last;
    end else if (pix_go && (row_q >= 16'd2)) begin
      p1_d.valid = 1'b1;
      p1_d.eor   = last_col;
      p1_d.eof   = 1'b0;
      p1_d.keep  = (row_q == 16'd2) || ((row_q - 16'd1) >= eff_h);
    end
  end

  bsd_row_mem #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_row_mem (
    .clk_i       (clk_i),
    .we_i        (pix_go),
    .wslot_i     (wslot_q),
    .col_i       (col_q),
    .wdata_i     (in_data_i.pixel_bgra),
    .cur_slot_i  (oslot),
    .above_slot_i(aslot),
    .cur_o       (cur_rd),
    .above_o     (above_rd)
  );

  bsd_run_mem #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_run_mem (
    .clk_i       (clk_i),
    .wslot_i     (wslot_q),
    .sidx_we_i   (pix_go && px_zero),
    .sidx_wcol_i (col_q),
    .sidx_wdata_i(run_start1),
    .len_we_i    (pix_go && run_close),
    .len_wcol_i  (close_start),
    .len_wdata_i (run_qual ? close_len : '0),
    .sidx_rslot_i(oslot),
    .sidx_rcol_i (col_q),
    .len_rslot_i (p1_q.oslot),
    .len_o       (len_rd)
  );

  // The pipeline never stalls; the result queue absorbs output back-pressure.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_q <= '0;
      p2_q <= '0;
    end else begin
      p1_q <= p1_d;
      p2_q <= p1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cur2_q   <= cur_rd;
    above2_q <= above_rd;
  end

  // A zero pixel inside a qualifying run takes the pixel above in adaptive
  // mode; plain mode swaps the whole marked row.
  bsd_pkg::out_beat_t res;

  always_comb begin
    res.end_of_row   = p2_q.eor;
    res.end_of_frame = p2_q.eof;
    if (p2_q.keep || !p2_q.rrow) begin
      res.pixel_out = cur2_q;
    end else if (p2_q.rall) begin
      res.pixel_out = above2_q;
    end else if ((cur2_q == 32'd0) && (len_rd != '0)) begin
      res.pixel_out = above2_q;
    end else begin
      res.pixel_out = cur2_q;
    end
  end

  bsd_out_fifo u_out_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (p2_q.valid),
    .push_data_i(res),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .level_o    (fifo_level)
  );

endmodule

@@ design/bsd_row_mem.sv @@
// ----------------------------------------------------------------------------
// Row store
// Three row slots of pixels, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module bsd_row_mem #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [1:0]                   wslot_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] col_i,
  input  logic [31:0]                  wdata_i,
  input  logic [1:0]                   cur_slot_i,
  input  logic [1:0]                   above_slot_i,
  output logic [31:0]                  cur_o,
  output logic [31:0]                  above_o
);

  logic [31:0] mem [3][MAX_WIDTH];

  // Reads return the old contents when the same entry is written.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wslot_i][col_i] <= wdata_i;
    end
    cur_o   <= mem[cur_slot_i][col_i];
    above_o <= mem[above_slot_i][col_i];
  end

endmodule

@@ design/bsd_run_mem.sv @@
// ----------------------------------------------------------------------------
// Run tables
// Per column run start index and per run start qualifying run length.
// ----------------------------------------------------------------------------
module bsd_run_mem #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                           clk_i,
  input  logic [1:0]                     wslot_i,
  input  logic                           sidx_we_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]   sidx_wcol_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]   sidx_wdata_i,
  input  logic                           len_we_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]   len_wcol_i,
  input  logic [$clog2(MAX_WIDTH+1)-1:0] len_wdata_i,
  input  logic [1:0]                     sidx_rslot_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]   sidx_rcol_i,
  input  logic [1:0]                     len_rslot_i,
  output logic [$clog2(MAX_WIDTH+1)-1:0] len_o
);

  localparam int unsigned ColW = $clog2(MAX_WIDTH);
  localparam int unsigned LenW = $clog2(MAX_WIDTH + 1);

  logic [ColW-1:0] sidx_mem [3][MAX_WIDTH];
  logic [LenW-1:0] len_mem  [3][MAX_WIDTH];
  logic [ColW-1:0] sidx_q;

  always_ff @(posedge clk_i) begin
    if (sidx_we_i) begin
      sidx_mem[wslot_i][sidx_wcol_i] <= sidx_wdata_i;
    end
    sidx_q <= sidx_mem[sidx_rslot_i][sidx_rcol_i];
  end

  // The length is looked up in the cycle after the start index, at the start of the pixel's run.
  always_ff @(posedge clk_i) begin
    if (len_we_i) begin
      len_mem[wslot_i][len_wcol_i] <= len_wdata_i;
    end
    len_o <= len_mem[len_rslot_i][sidx_q];
  end

endmodule

@@ design/bsd_out_fifo.sv @@
// ----------------------------------------------------------------------------
// Output queue
// Small result queue that decouples the read pipeline from output stall.
// ----------------------------------------------------------------------------
module bsd_out_fifo (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push_i,
  input  bsd_pkg::out_beat_t              push_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output bsd_pkg::out_beat_t              out_data_o,
  output logic [bsd_pkg::FifoCntW-1:0]    level_o
);

  bsd_pkg::out_beat_t                buf_q [bsd_pkg::FifoDepth];
  logic [bsd_pkg::FifoPtrW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [bsd_pkg::FifoCntW-1:0]      cnt_q;
  logic                              pop;

  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && !out_stall_i;
  assign out_data_o  = buf_q[rd_ptr_q];
  assign level_o     = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push_i, pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ design/bsd_checker.sv @@
// ----------------------------------------------------------------------------
// Port checker
// Watches the ports of the doubler core for timing and framing slips.
// ----------------------------------------------------------------------------
module bsd_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input bsd_pkg::in_beat_t            in_data_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input bsd_pkg::out_beat_t           out_data_o,
  input logic                         cfg_valid_i,
  input logic                         cfg_ready_o,
  input logic [bsd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input logic [bsd_pkg::CfgDataW-1:0] cfg_data_i
);

  // A stalled result beat stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat changed while stalled");

  // A frame always ends on a row end.
  a_eof_eor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.end_of_frame |-> out_data_o.end_of_row)
    else $error("end of frame without end of row");

  // No result is offered while in reset.
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

  // Input is held off only while results are waiting at the output.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with an empty output");

  // A result first shows up only after an input beat has passed the read pipeline.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 3))
    else $error("result appeared without a matching input beat");

endmodule

bind blank_scanline_doubler_core bsd_checker u_bsd_checker (.*);

@@ tb/sv/blank_scanline_doubler_core_tb.sv @@
// ----------------------------------------------------------------------------
// Blank scanline doubler core testbench
// Streams small frames through the core under several register settings and
// checks every output beat against a cycle-free prediction of the row filling.
// ----------------------------------------------------------------------------
module blank_scanline_doubler_core_tb;
  import bsd_pkg::*;

  localparam int unsigned MaxW = 1024;
  localparam int unsigned WatchdogLimit = 4000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_beat_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_beat_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  always #1 clk_i = ~clk_i;

  blank_scanline_doubler_core #(.MAX_WIDTH(MaxW)) u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  // Pixel beats waiting to be sent and output beats still owed by the core.
  in_beat_t  pending_beats[$];
  out_beat_t owed_pixels[$];
  int unsigned errors = 0;
  int unsigned cycle = 0;
  int unsigned quiet_cycles = 0;
  logic sender_hold = 1'b0;

  // Idling is switched off for one long window so back-to-back beats happen.
  function automatic logic want_idle();
    if (cycle > 3000 && cycle < 9000) return 1'b0;
    return $urandom_range(99) < 10;
  endfunction

  // --------------------------------------------------------------------------
  // Predictor state: a shadow of the registers and of the row machinery.
  // --------------------------------------------------------------------------
  int unsigned sh_mode, sh_width, sh_height, sh_cutoff, sh_minrun;
  logic [31:0] row_pix[0:3*MaxW-1];
  int unsigned run_len[0:2*MaxW-1];
  int unsigned zero_total[2];
  int unsigned data_flags, run_open_len, run_open_start;
  int unsigned col_pos, row_pos, tail_left;
  logic fill_row, fill_whole;

  task automatic shadow_reset();
    sh_mode = LineModeReset; sh_width = RowWidthReset; sh_height = HeightReset;
    sh_cutoff = CutoffReset; sh_minrun = MinRunReset;
    for (int i = 0; i < 3*MaxW; i++) row_pix[i] = '0;
    for (int i = 0; i < 2*MaxW; i++) run_len[i] = 0;
    zero_total[0] = 0; zero_total[1] = 0;
    data_flags = 0; run_open_len = 0; run_open_start = 0;
    col_pos = 0; row_pos = 0; tail_left = 0;
    fill_row = 1'b0; fill_whole = 1'b0;
  endtask

  task automatic shadow_write(cfg_idx_e idx, logic [15:0] value);
    case (idx)
      CFG_LINE_MODE:    sh_mode = value[0];
      CFG_ROW_WIDTH:    sh_width = value[10:0];
      CFG_FRAME_HEIGHT: sh_height = value;
      CFG_BLANK_CUTOFF: sh_cutoff = value[10:0];
      CFG_MIN_RUN:      sh_minrun = value[10:0];
      default: ;
    endcase
  endtask

  // A zero run that is long enough marks its columns and adds to the row sum.
  task automatic close_zero_run(int unsigned slot);
    if (run_open_len > 0 && run_open_len >= sh_minrun) begin
      for (int unsigned i = 0; i < run_open_len; i++)
        if (run_open_start + i < MaxW) run_len[slot*MaxW + run_open_start + i] = run_open_len;
      zero_total[slot] += run_open_len;
    end
    run_open_len = 0;
  endtask

  function automatic logic [31:0] filled_pixel(int unsigned orow, int unsigned col,
                                               int unsigned h);
    logic [31:0] cur, above;
    cur = row_pix[(orow % 3)*MaxW + col];
    above = row_pix[((orow + 2) % 3)*MaxW + col];
    if (orow == 0 || orow + 1 >= h || !fill_row) return cur;
    if (fill_whole) return above;
    if (run_len[(orow & 1)*MaxW + col] != 0) return above;
    return cur;
  endfunction

  // Advances the shadow by one accepted input beat and queues what it owes.
  task automatic predict_beat(in_beat_t b);
    int unsigned w, h, c, r, slot;
    logic eor, eof, prev_data, this_data;
    out_beat_t o;
    w = (sh_width == 0) ? 1 : (sh_width > MaxW ? MaxW : sh_width);
    h = (sh_height == 0) ? 1 : sh_height;
    c = col_pos % MaxW;
    r = row_pos;
    slot = r & 1;
    if (tail_left > 0) begin
      // While the tail drains, pixel beats are dropped silently.
      if (op_e'(b.operation) == OP_PIXEL) return;
      eof = (tail_left == 1);
      eor = eof || (c + 1 >= w);
      o.pixel_out = filled_pixel(r, c, h);
      o.end_of_row = eor;
      o.end_of_frame = eof;
      owed_pixels.push_back(o);
      tail_left--;
      if (tail_left == 0) begin
        row_pos = 0; col_pos = 0; data_flags = 0; run_open_len = 0; fill_row = 1'b0;
      end else if (eor) begin
        col_pos = 0; row_pos = (r + 1) & 16'hFFFF;
      end else begin
        col_pos = c + 1;
      end
      return;
    end
    if (op_e'(b.operation) == OP_DRAIN) return;
    if (c == 0) begin
      zero_total[slot] = 0; run_open_len = 0; data_flags &= 2;
    end
    if (r >= 2) begin
      o.pixel_out = filled_pixel(r - 2, c, h);
      o.end_of_row = (c + 1 >= w);
      o.end_of_frame = 1'b0;
      owed_pixels.push_back(o);
    end
    row_pix[(r % 3)*MaxW + c] = b.pixel_bgra;
    run_len[slot*MaxW + c] = 0;
    if (b.pixel_bgra == 0) begin
      if (run_open_len == 0) run_open_start = c;
      run_open_len++;
    end else begin
      close_zero_run(slot);
      data_flags |= 1;
    end
    if (c + 1 >= w) begin
      prev_data = (data_flags & 2) != 0;
      this_data = (data_flags & 1) != 0;
      close_zero_run(slot);
      // The decision for the row above is frozen here, with the current registers.
      if (r >= 1) begin
        if (line_mode_e'(sh_mode[0]) == MODE_PLAIN) begin
          fill_row = !prev_data && this_data; fill_whole = 1'b1;
        end else begin
          fill_row = this_data && (zero_total[(r - 1) & 1] > sh_cutoff);
          fill_whole = 1'b0;
        end
      end else begin
        fill_row = 1'b0;
      end
      data_flags = this_data ? 2 : 0;
      col_pos = 0;
      if (r + 1 >= h) begin
        tail_left = w * (h < 2 ? h : 2);
        row_pos = h - (h < 2 ? h : 2);
      end else begin
        row_pos = (r + 1) & 16'hFFFF;
      end
    end else begin
      col_pos = c + 1;
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: presents queued beats, keeps a stalled beat steady, predicts on
  // every accepted beat.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_beat(in_data);
      if (in_valid && in_stall) begin
        // Beat is held until the core takes it.
      end else if (pending_beats.size() > 0 && !sender_hold && !want_idle()) begin
        in_valid <= 1'b1;
        in_data <= pending_beats.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: random back-pressure, and each taken beat is checked in order.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (owed_pixels.size() == 0) begin
          errors++;
          $display("%0t: unexpected output beat %h", $time, out_data);
        end else begin
          out_beat_t want;
          want = owed_pixels.pop_front();
          if (want.pixel_out !== out_data.pixel_out) begin
            errors++;
            $display("%0t: pixel_out expected %h got %h", $time, want.pixel_out,
                     out_data.pixel_out);
          end
          if (want.end_of_row !== out_data.end_of_row) begin
            errors++;
            $display("%0t: end_of_row expected %b got %b", $time, want.end_of_row,
                     out_data.end_of_row);
          end
          if (want.end_of_frame !== out_data.end_of_frame) begin
            errors++;
            $display("%0t: end_of_frame expected %b got %b", $time, want.end_of_frame,
                     out_data.end_of_frame);
          end
        end
      end
      out_stall <= want_idle();
    end
  end

  // Watchdog: too long without any beat moving on any channel ends the run.
  always @(posedge clk_i) begin
    cycle <= cycle + 1;
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WatchdogLimit) begin
      $display("blank_scanline_doubler_core_tb: errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencing helpers.
  // --------------------------------------------------------------------------
  task automatic reg_write(cfg_idx_e idx, logic [15:0] value);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk_i); while (!cfg_ready);
    shadow_write(idx, value);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_all(int unsigned mode, int unsigned w, int unsigned h,
                         int unsigned cut, int unsigned minrun);
    reg_write(CFG_LINE_MODE, mode);
    reg_write(CFG_ROW_WIDTH, w);
    reg_write(CFG_FRAME_HEIGHT, h);
    reg_write(CFG_BLANK_CUTOFF, cut);
    reg_write(CFG_MIN_RUN, minrun);
  endtask

  // Waits until every queued beat is sent and every owed result has come,
  // then lets the pipeline empty before any register is touched.
  task automatic settle();
    while (pending_beats.size() > 0 || in_valid || owed_pixels.size() > 0)
      @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_pixel();
    case ($urandom_range(7))
      0: return 32'hFFFF_FFFF;
      1: return 32'h1 << $urandom_range(31);
      default: return $urandom();
    endcase
  endfunction

  task automatic push_pixel(logic [31:0] p);
    in_beat_t b;
    b.operation = OP_PIXEL;
    b.pixel_bgra = p;
    pending_beats.push_back(b);
  endtask

  task automatic push_drain();
    in_beat_t b;
    b.operation = OP_DRAIN;
    b.pixel_bgra = $urandom();
    pending_beats.push_back(b);
  endtask

  // Queues one whole frame plus its drain beats, with occasional noise:
  // idle drains before it and stray pixels inside the tail.
  task automatic push_frame(int unsigned w_reg, int unsigned h_reg, int unsigned noise,
                            ref int unsigned pixel_count);
    int unsigned w, h, kind, tail;
    logic in_zero;
    w = (w_reg == 0) ? 1 : (w_reg > MaxW ? MaxW : w_reg);
    h = (h_reg == 0) ? 1 : h_reg;
    if ($urandom_range(99) < noise) push_drain();
    for (int unsigned r = 0; r < h; r++) begin
      kind = $urandom_range(9);
      in_zero = $urandom_range(1);
      for (int unsigned c = 0; c < w; c++) begin
        if (kind < 3) begin
          push_pixel('0);
        end else if (kind < 7) begin
          // Rows with zero runs of random length.
          if ($urandom_range(3) == 0) in_zero = ~in_zero;
          push_pixel(in_zero ? 32'h0 : rand_pixel());
        end else begin
          push_pixel(($urandom_range(5) == 0) ? 32'h0 : rand_pixel());
        end
        pixel_count++;
      end
    end
    tail = w * (h < 2 ? h : 2);
    for (int unsigned i = 0; i < tail; i++) begin
      if ($urandom_range(99) < noise) push_pixel(rand_pixel());
      push_drain();
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned count, w, h;
    shadow_reset();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    count = 0;

    // Plain mode: data row, blank row, data rows, so the blank row is doubled.
    // An idle drain comes first and a stray pixel lands in the tail.
    set_all(MODE_PLAIN, 4, 4, 0, 1);
    push_drain();
    for (int i = 0; i < 4; i++) push_pixel(32'h0101_0101 << i);
    for (int i = 0; i < 4; i++) push_pixel(32'h0);
    for (int i = 0; i < 4; i++) push_pixel(32'hFFFF_FFFF);
    for (int i = 0; i < 4; i++) push_pixel(32'h8000_0001);
    push_pixel(32'hDEAD_BEEF);
    for (int i = 0; i < 8; i++) push_drain();
    settle();

    // Adaptive mode with short runs and a small cutoff.
    set_all(MODE_ADAPTIVE, 8, 5, 2, 3);
    push_frame(8, 5, 10, count);
    settle();

    // Single-row frame, and width zero acting as one.
    set_all(MODE_ADAPTIVE, 3, 1, 0, 0);
    push_frame(3, 1, 0, count);
    settle();
    set_all(MODE_PLAIN, 0, 2, 1024, 1024);
    push_frame(0, 2, 0, count);
    settle();

    // Oversized width clamps to the store width.
    set_all(MODE_ADAPTIVE, 2047, 1, 1024, 1);
    push_frame(2047, 1, 0, count);
    settle();
    set_all(MODE_ADAPTIVE, 1024, 3, 0, 1024);
    push_frame(1024, 3, 0, count);
    settle();

    // Tallest frame: a few rows in, then the height is lowered so it closes.
    set_all(MODE_PLAIN, 1, 65535, 0, 30);
    for (int i = 0; i < 5; i++) push_pixel(i[0] ? 32'h0 : rand_pixel());
    settle();
    reg_write(CFG_FRAME_HEIGHT, 6);
    push_pixel(rand_pixel());
    push_drain();
    push_drain();
    settle();

    // Random phases until about 600 pixel beats have gone in.
    count = 0;
    while (count < 600) begin
      w = ($urandom_range(9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
      h = $urandom_range(1, 8);
      set_all($urandom_range(1), w, h, $urandom_range(0, 12), $urandom_range(0, 6));
      for (int f = $urandom_range(1, 3); f > 0; f--) push_frame(w, h, 5, count);
      // Now and then the sender holds off until the core has caught up.
      if ($urandom_range(3) == 0) begin
        sender_hold = 1'b1;
        while (owed_pixels.size() > 0 || in_valid) @(posedge clk_i);
        sender_hold = 1'b0;
      end
      settle();
    end

    if (errors == 0) begin
      $display("blank_scanline_doubler_core_tb: clean");
    end else begin
      $display("blank_scanline_doubler_core_tb: errors");
    end
    $finish;
  end

endmodule
